// File: hdl/pc1_stream_cipher_128_unit_macros.svh
// Assertion macros used by the cipher unit's top-level RTL file.
`ifndef PC1_STREAM_CIPHER_128_UNIT_MACROS_SVH
`define PC1_STREAM_CIPHER_128_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define PC1_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pc1 assertion failed");

// Next-cycle implication, checked out of reset.
`define PC1_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pc1 assertion failed");

`else

`define PC1_ASSERT_IMPL(lbl, ante, cons)
`define PC1_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/pc1sc_pkg.sv
// Shared types and constants of the PC1 stream cipher unit.
package pc1sc_pkg;

  localparam int ROUNDS    = 8;
  localparam int KEY_BYTES = 2 * ROUNDS;
  localparam int CFG_DW    = 64;
  localparam int CFG_AW    = 5;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_MODE     = 2'd2;

  localparam logic [15:0] MUL_K_LO = 16'h015a;
  localparam logic [15:0] MUL_K_HI = 16'h4e35;
  localparam logic [7:0]  LETTER_BASE8 = 8'h61;
  localparam logic [6:0]  LETTER_BASE7 = 7'h61;

  typedef enum logic {
    MUL_SEL_015A = 1'b0,
    MUL_SEL_4E35 = 1'b1
  } mul_k_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic        decrypt_mode;
  } cfg_regs_t;

endpackage

// File: hdl/pc1sc_if.sv
// Valid/ready channel interfaces for the cipher unit's input and result streams.
interface pc1sc_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] plain_byte;
  logic [7:0] letter_high;
  logic [7:0] letter_low;

  modport source (output valid, start_req, plain_byte, letter_high, letter_low,
                  input ready);
  modport sink (input valid, start_req, plain_byte, letter_high, letter_low,
                output ready);
endinterface

interface pc1sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [6:0] out_letter_high;
  logic [6:0] out_letter_low;

  modport source (output valid, out_byte, out_letter_high, out_letter_low,
                  input ready);
  modport sink (input valid, out_byte, out_letter_high, out_letter_low,
                output ready);
endinterface

// File: hdl/pc1_stream_cipher_128_unit.sv
// Top level of the PC1 stream cipher unit: sequencer, key store and output register.
//
// The input channel carries one byte request at a time: start_req, plain_byte and the
// two letters. In encrypt mode plain_byte is used; in decrypt mode the two letters are.
// A request with start_req set reloads the working key from the key registers and
// clears both chaining words before its byte is processed.
// Each byte runs eight rounds of three steps on one shared 16-bit multiplier,
// followed by a finishing step that loads the result into the output register; a new
// request is accepted only in the idle state after that, so one byte is worked on at a time.
// The result request waits in the output register; the next input request may be
// accepted and worked on while it waits. If the receiver still stalls when the next
// result is ready, the unit holds that result in its finishing step.
// Reset clears the key registers, the mode, the working key and the chaining words.
// Configuration writes go through the APB-style port at byte addresses 0, 8 and 16
// and are to be only made while the unit is idle; the unit itself does not enforce this.
module pc1_stream_cipher_128_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  pc1sc_in_if.sink                     in_ch,
  pc1sc_out_if.source                  out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pc1sc_pkg::CFG_AW-1:0] paddr,
  input  logic [pc1sc_pkg::CFG_DW-1:0] pwdata,
  output logic [pc1sc_pkg::CFG_DW-1:0] prdata,
  output logic                         pready
);
  import pc1sc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_A    = 5'b00010,
    ST_B    = 5'b00100,
    ST_C    = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  localparam int RW = $clog2(ROUNDS);

  cfg_regs_t   regs;

  state_t      state_r, state_nxt;
  logic [RW-1:0] rnd_r, rnd_nxt;
  logic [7:0]  wk_r [KEY_BYTES];
  logic [7:0]  wk_nxt [KEY_BYTES];
  logic [15:0] chain_sum_r, chain_sum_nxt;
  logic [15:0] chain_prod_r, chain_prod_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [15:0] acc_r, acc_nxt;
  logic [15:0] word_r, word_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [15:0] wprod_r, wprod_nxt;
  logic [7:0]  plain_r, plain_nxt;
  logic [7:0]  lhi_r, lhi_nxt;
  logic [7:0]  llo_r, llo_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [6:0]  out_lh_r, out_lh_nxt;
  logic [6:0]  out_ll_r, out_ll_nxt;

  logic        in_acc;
  logic        out_free;
  logic [15:0] prod_r;
  logic [15:0] mul_opnd;
  mul_k_t      mul_sel;
  logic        mul_en;
  logic [15:0] mod_w;
  logic [15:0] kw;
  logic [15:0] word_w;
  logic [15:0] acc_w;
  logic [7:0]  ks;
  logic [7:0]  c_dec;
  logic [7:0]  c_enc;
  logic [7:0]  p_byte;

  pc1sc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  pc1sc_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .opnd   (mul_opnd),
    .k_sel  (mul_sel),
    .prod_r (prod_r)
  );

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign in_acc                 = in_ch.valid & in_ch.ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_byte        = out_byte_r;
  assign out_ch.out_letter_high = out_lh_r;
  assign out_ch.out_letter_low  = out_ll_r;
  assign out_free               = ~out_valid_r | out_ch.ready;

  // The multiplier holds word * 0x4e35 of the previous round, so mod is one increment away.
  assign mod_w  = prod_r + 16'd1;
  assign kw     = {wk_r[0], wk_r[1]};
  assign word_w = (rnd_r == '0) ? kw : (mod_w ^ kw);
  assign acc_w  = acc_r ^ mod_w ^ chain_sum_r;
  assign ks     = acc_w[15:8] ^ acc_w[7:0];
  assign c_dec  = 8'((lhi_r - LETTER_BASE8) << 4) + 8'(llo_r - LETTER_BASE8);
  assign c_enc  = plain_r ^ ks;
  assign p_byte = regs.decrypt_mode ? (c_dec ^ ks) : plain_r;

  always_comb begin
    case (state_r)
      ST_A: begin
        mul_opnd = word_w;
        mul_sel  = MUL_SEL_015A;
        mul_en   = 1'b1;
      end
      ST_B: begin
        mul_opnd = idx_r;
        mul_sel  = MUL_SEL_4E35;
        mul_en   = 1'b1;
      end
      ST_C: begin
        mul_opnd = word_r;
        mul_sel  = MUL_SEL_4E35;
        mul_en   = 1'b1;
      end
      default: begin
        mul_opnd = word_r;
        mul_sel  = MUL_SEL_015A;
        mul_en   = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    rnd_nxt        = rnd_r;
    wk_nxt         = wk_r;
    chain_sum_nxt  = chain_sum_r;
    chain_prod_nxt = chain_prod_r;
    acc_nxt        = acc_r;
    word_nxt       = word_r;
    idx_nxt        = idx_r;
    wprod_nxt      = wprod_r;
    plain_nxt      = plain_r;
    lhi_nxt        = lhi_r;
    llo_nxt        = llo_r;
    out_byte_nxt   = out_byte_r;
    out_lh_nxt     = out_lh_r;
    out_ll_nxt     = out_ll_r;
    out_valid_nxt  = out_valid_r & ~out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          plain_nxt = in_ch.plain_byte;
          lhi_nxt   = in_ch.letter_high;
          llo_nxt   = in_ch.letter_low;
          acc_nxt   = '0;
          rnd_nxt   = '0;
          state_nxt = ST_A;
          if (in_ch.start_req) begin
            for (int i = 0; i < KEY_BYTES / 2; i++) begin
              wk_nxt[i]                 = regs.key_high[8*(KEY_BYTES/2-1-i) +: 8];
              wk_nxt[KEY_BYTES / 2 + i] = regs.key_low[8*(KEY_BYTES/2-1-i) +: 8];
            end
            chain_sum_nxt  = '0;
            chain_prod_nxt = '0;
          end
        end
      end
      ST_A: begin
        word_nxt = word_w;
        idx_nxt  = chain_sum_r + 16'(rnd_r);
        if (rnd_r != '0) begin
          acc_nxt = acc_w;
        end
        state_nxt = ST_B;
      end
      ST_B: begin
        wprod_nxt = prod_r;
        state_nxt = ST_C;
      end
      ST_C: begin
        chain_sum_nxt  = prod_r + wprod_r + chain_prod_r;
        chain_prod_nxt = wprod_r;
        // Rotating by two bytes a round keeps the current key word at bytes 0 and 1.
        for (int i = 0; i < KEY_BYTES; i++) begin
          wk_nxt[i] = wk_r[(i + 2) % KEY_BYTES];
        end
        rnd_nxt   = rnd_r + RW'(1);
        state_nxt = (rnd_r == RW'(ROUNDS - 1)) ? ST_FIN : ST_A;
      end
      ST_FIN: begin
        if (out_free) begin
          for (int i = 0; i < KEY_BYTES; i++) begin
            wk_nxt[i] = wk_r[i] ^ p_byte;
          end
          out_valid_nxt = 1'b1;
          if (regs.decrypt_mode) begin
            out_byte_nxt = p_byte;
            out_lh_nxt   = '0;
            out_ll_nxt   = '0;
          end else begin
            out_byte_nxt = c_enc;
            out_lh_nxt   = LETTER_BASE7 + {3'b000, c_enc[7:4]};
            out_ll_nxt   = LETTER_BASE7 + {3'b000, c_enc[3:0]};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rnd_r        <= '0;
      chain_sum_r  <= '0;
      chain_prod_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < KEY_BYTES; i++) begin
        wk_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      rnd_r        <= rnd_nxt;
      chain_sum_r  <= chain_sum_nxt;
      chain_prod_r <= chain_prod_nxt;
      out_valid_r  <= out_valid_nxt;
      wk_r         <= wk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    word_r     <= word_nxt;
    idx_r      <= idx_nxt;
    wprod_r    <= wprod_nxt;
    plain_r    <= plain_nxt;
    lhi_r      <= lhi_nxt;
    llo_r      <= llo_nxt;
    out_byte_r <= out_byte_nxt;
    out_lh_r   <= out_lh_nxt;
    out_ll_r   <= out_ll_nxt;
  end

`include "pc1_stream_cipher_128_unit_macros.svh"

  `PC1_ASSERT_NEXT(a_accept_starts_round, in_acc, state_r == ST_A)
  `PC1_ASSERT_NEXT(a_fin_holds_on_stall, (state_r == ST_FIN) && !out_free, state_r == ST_FIN)
  `PC1_ASSERT_NEXT(a_start_loads_key, in_acc && in_ch.start_req,
                   wk_r[0] == $past(regs.key_high[63:56]) && chain_sum_r == 16'd0)
  `PC1_ASSERT_IMPL(a_result_from_fin, $rose(out_valid_r), $past(state_r) == ST_FIN)

endmodule

// File: hdl/pc1sc_cfg.sv
// APB-style register file holding the key words and the mode bit.
module pc1sc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pc1sc_pkg::CFG_AW-1:0]    paddr,
  input  logic [pc1sc_pkg::CFG_DW-1:0]    pwdata,
  output logic [pc1sc_pkg::CFG_DW-1:0]    prdata,
  output logic                            pready,
  output pc1sc_pkg::cfg_regs_t            regs
);
  import pc1sc_pkg::*;

  cfg_regs_t  regs_r;
  cfg_regs_t  regs_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  // Registers sit on 8-byte boundaries, so the low three address bits are ignored.
  assign reg_idx = paddr[CFG_AW-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign regs    = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (reg_idx)
        REG_KEY_HIGH: regs_nxt.key_high     = pwdata;
        REG_KEY_LOW:  regs_nxt.key_low      = pwdata;
        REG_MODE:     regs_nxt.decrypt_mode = pwdata[0];
        default:      regs_nxt = regs_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY_HIGH: prdata = regs_r.key_high;
      REG_KEY_LOW:  prdata = regs_r.key_low;
      REG_MODE:     prdata = {{(CFG_DW-1){1'b0}}, regs_r.decrypt_mode};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// File: hdl/pc1sc_mul.sv
// Shared 16-bit modular multiplier by one of the two round constants, product registered.
module pc1sc_mul (
  input  logic              clk,
  input  logic              en,
  input  logic [15:0]       opnd,
  input  pc1sc_pkg::mul_k_t k_sel,
  output logic [15:0]       prod_r
);
  import pc1sc_pkg::*;

  logic [15:0] kval;
  logic [31:0] full;
  logic [15:0] prod_nxt;

  always_comb begin
    case (k_sel)
      MUL_SEL_015A: kval = MUL_K_LO;
      MUL_SEL_4E35: kval = MUL_K_HI;
      default:      kval = MUL_K_LO;
    endcase
  end

  // Only the low 16 bits of the product are kept.
  assign full     = opnd * kval;
  assign prod_nxt = en ? full[15:0] : prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: verif/pc1_stream_cipher_128_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the PC1 cipher unit: queued byte requests checked against a predictor.
module pc1_stream_cipher_128_unit_test;
  import pc1sc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int SEGMENTS       = 8;
  localparam int SEGMENT_REQS   = 190;

  typedef struct {
    logic       start;
    logic [7:0] plain;
    logic [7:0] let_hi;
    logic [7:0] let_lo;
  } byte_req_t;

  typedef struct {
    logic [7:0] data;
    logic [6:0] let_hi;
    logic [6:0] let_lo;
  } cipher_out_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  pc1sc_in_if  in_ch ();
  pc1sc_out_if out_ch ();

  pc1_stream_cipher_128_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  byte_req_t   pending_reqs[$];
  cipher_out_t expected_outs[$];
  byte_req_t   active_req;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          reqs_accepted;
  int          outs_checked;
  int          mismatches;
  int          idle_cycles;

  // Predictor copy of the configuration and of the cipher state.
  logic [63:0] key_high_reg;
  logic [63:0] key_low_reg;
  logic        decrypt_reg;
  logic [7:0]  work_key [KEY_BYTES];
  logic [15:0] chain_sum;
  logic [15:0] chain_prod;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Works out the result of one byte request and advances the cipher state.
  function automatic cipher_out_t predict_cipher(byte_req_t r);
    cipher_out_t o;
    logic [15:0] acc;
    logic [15:0] prev;
    logic [15:0] kw;
    logic [15:0] word;
    logic [15:0] idx;
    logic [15:0] sum;
    logic [15:0] modv;
    logic [7:0]  ks;
    logic [7:0]  c;
    logic [7:0]  p;
    if (r.start) begin
      for (int i = 0; i < 8; i++) begin
        work_key[i]     = key_high_reg[63 - 8 * i -: 8];
        work_key[8 + i] = key_low_reg[63 - 8 * i -: 8];
      end
      chain_sum  = '0;
      chain_prod = '0;
    end
    acc  = '0;
    prev = '0;
    for (int rd = 0; rd < ROUNDS; rd++) begin
      kw         = {work_key[2 * rd], work_key[2 * rd + 1]};
      word       = (rd == 0) ? kw : (prev ^ kw);
      idx        = chain_sum + 16'(rd);
      sum        = idx * MUL_K_HI + word * MUL_K_LO + chain_prod;
      modv       = word * MUL_K_HI + 16'd1;
      chain_prod = word * MUL_K_LO;
      chain_sum  = sum;
      prev       = modv;
      acc        = acc ^ modv ^ sum;
    end
    ks = acc[15:8] ^ acc[7:0];
    if (decrypt_reg) begin
      // Out-of-range letters simply wrap within eight bits.
      c        = ((r.let_hi - LETTER_BASE8) << 4) + (r.let_lo - LETTER_BASE8);
      p        = c ^ ks;
      o.data   = p;
      o.let_hi = '0;
      o.let_lo = '0;
    end else begin
      p        = r.plain;
      c        = p ^ ks;
      o.data   = c;
      o.let_hi = LETTER_BASE7 + {3'b000, c[7:4]};
      o.let_lo = LETTER_BASE7 + {3'b000, c[3:0]};
    end
    for (int i = 0; i < KEY_BYTES; i++) begin
      work_key[i] = work_key[i] ^ p;
    end
    return o;
  endfunction

  // Request driver: a new request goes out once the previous one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.start_req   <= 1'b0;
      in_ch.plain_byte  <= '0;
      in_ch.letter_high <= '0;
      in_ch.letter_low  <= '0;
      // The predictor starts from the same cleared state as the unit.
      for (int i = 0; i < KEY_BYTES; i++) work_key[i] = '0;
      chain_sum  = '0;
      chain_prod = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_outs.push_back(predict_cipher(active_req));
        reqs_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          active_req = pending_reqs.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.start_req   <= active_req.start;
          in_ch.plain_byte  <= active_req.plain;
          in_ch.letter_high <= active_req.let_hi;
          in_ch.letter_low  <= active_req.let_lo;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    cipher_out_t exp_out;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        outs_checked++;
        if (expected_outs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %h with no request outstanding", $realtime,
                     out_ch.out_byte);
        end else begin
          exp_out = expected_outs.pop_front();
          if (out_ch.out_byte !== exp_out.data || out_ch.out_letter_high !== exp_out.let_hi ||
              out_ch.out_letter_low !== exp_out.let_lo) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d expected byte %h letters %h %h, got %h %h %h",
                       $realtime, outs_checked, exp_out.data, exp_out.let_hi, exp_out.let_lo,
                       out_ch.out_byte, out_ch.out_letter_high, out_ch.out_letter_low);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog on cycles without any handshake or register access.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_outs.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] reg_idx, logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      REG_KEY_HIGH: key_high_reg = value;
      REG_KEY_LOW:  key_low_reg  = value;
      default:      decrypt_reg  = value[0];
    endcase
  endtask

  task automatic add_req(logic start, logic [7:0] plain, logic [7:0] lh, logic [7:0] ll);
    byte_req_t r;
    r.start  = start;
    r.plain  = plain;
    r.let_hi = lh;
    r.let_lo = ll;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_outs.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          queued;
    int          msg_len;
    logic        start;
    logic [7:0]  lh;
    logic [7:0]  ll;
    logic [63:0] kh;
    logic [63:0] kl;
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    key_high_reg       = '0;
    key_low_reg        = '0;
    decrypt_reg        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // No start yet: the unit runs on the cleared working key.
    add_req(1'b0, 8'h00, 8'h00, 8'hff);
    add_req(1'b0, 8'hff, 8'hff, 8'h00);
    wait_drained();

    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '0);
    add_req(1'b1, 8'h00, 8'h61, 8'h61);
    add_req(1'b0, 8'hff, 8'h70, 8'h70);
    add_req(1'b0, 8'h80, 8'h00, 8'h00);
    add_req(1'b0, 8'h01, 8'hff, 8'hff);
    add_req(1'b0, 8'h7f, 8'h55, 8'haa);
    add_req(1'b1, 8'ha5, 8'haa, 8'h55);
    wait_drained();

    // A new key must not affect the running message until the next start.
    write_reg(REG_KEY_HIGH, 64'h0123_4567_89ab_cdef);
    write_reg(REG_KEY_LOW, 64'hfedc_ba98_7654_3210);
    add_req(1'b0, 8'h3c, 8'h61, 8'h62);
    add_req(1'b0, 8'hc3, 8'h63, 8'h64);
    add_req(1'b1, 8'h5a, 8'h65, 8'h66);
    wait_drained();

    write_reg(REG_MODE, 64'd1);
    write_reg(REG_KEY_LOW, '1);
    add_req(1'b1, 8'h00, 8'h61, 8'h61);
    add_req(1'b0, 8'hff, 8'h70, 8'h70);
    add_req(1'b0, 8'h00, 8'h61, 8'h70);
    add_req(1'b0, 8'hff, 8'h00, 8'hff);
    add_req(1'b0, 8'h00, 8'hff, 8'h00);
    add_req(1'b0, 8'hff, 8'h71, 8'h60);
    add_req(1'b1, 8'h00, 8'h68, 8'h6b);
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
        default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
      endcase
      if (seg == 0) begin
        kh = '0;
        kl = '0;
      end else if (seg == 1) begin
        kh = '1;
        kl = '1;
      end else begin
        kh = {$urandom, $urandom};
        kl = {$urandom, $urandom};
      end
      write_reg(REG_KEY_HIGH, kh);
      write_reg(REG_KEY_LOW, kl);
      write_reg(REG_MODE, 64'(seg % 2));
      queued = 0;
      while (queued < SEGMENT_REQS) begin
        msg_len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 32);
        for (int b = 0; b < msg_len; b++) begin
          // Mostly proper messages; now and then a missing or stray start.
          start = (b == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
          lh = LETTER_BASE8 + 8'($urandom_range(15));
          ll = LETTER_BASE8 + 8'($urandom_range(15));
          if ($urandom_range(9) == 0) lh = 8'($urandom);
          if ($urandom_range(9) == 0) ll = 8'($urandom);
          add_req(start, 8'($urandom), lh, ll);
          queued++;
        end
      end
      wait_drained();
    end

    $display("Run covered %0d byte requests and %0d results under %0d key and mode settings,",
             reqs_accepted, outs_checked, SEGMENTS + 4);
    $display("with encrypt and decrypt messages under four sender and receiver idling mixes.");
    if (mismatches == 0 && expected_outs.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
